>>> sv/smtd_pkg.sv
// ----------------------------------------------------------------------------
// smtd_pkg
// types, codes and constants shared by the sorted merge with time dedup block
// ----------------------------------------------------------------------------
`default_nettype none

package smtd_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int DATA_W         = 64;
  localparam int GAP_W          = 32;
  localparam int TOL_W          = 32;
  localparam int TALLY_W        = 7;
  localparam int FUNC_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int FRAC_W         = 24;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  localparam logic [FUNC_W-1:0] FUNC_LOAD_EXIST = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_FRESH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME_GAP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] sample_time;
    logic signed [DATA_W-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_time;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_valid;
    logic [TALLY_W-1:0]       mismatch_count;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] ptime;
    logic signed [DATA_W-1:0] pval;
  } pair_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_PICK,
    ST_TEST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CHECK,
    ST_EMIT,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic accept;
    logic pick;
    logic test;
    logic mul_lo;
    logic mul_hi;
    logic check;
    logic emit;
    logic final_out;
  } cmd_t;

  typedef struct packed {
    logic run_req;
    logic done;
    logic keep;
    logic cmp_en;
    logic out_free;
    logic pend_vld;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/sorted_merge_time_dedup.sv
// ----------------------------------------------------------------------------
// sorted_merge_time_dedup
// load: one word per cycle while idle, no result. run: an accept step, then per
// merged pair a read, pick and gap test, then a keep step, a mismatch compare
// on the shared 32x32 multiplier (low, high, check) or none for a silent drop,
// then read and final for the last word; output stalls hold keep and final.
// synchronous active-low reset clears counts, config and flags; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_merge_time_dedup import smtd_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  smtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  smtd_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

>>> sv/smtd_ctrl.sv
// ----------------------------------------------------------------------------
// smtd_ctrl
// sequencer for loads and the merge run: read, pick, test, compare, emit
// ----------------------------------------------------------------------------
`default_nettype none

module smtd_ctrl import smtd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.run_req) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = sts.done ? ST_FINAL : ST_PICK;
      end
      ST_PICK: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (sts.keep) state_nxt = ST_EMIT;
        else if (sts.cmp_en) state_nxt = ST_MUL_LO;
        else state_nxt = ST_READ;
      end
      ST_MUL_LO: begin
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_READ;
      end
      ST_EMIT: begin
        if (sts.out_free || !sts.pend_vld) state_nxt = ST_READ;
      end
      ST_FINAL: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_READ: begin
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
      end
      ST_TEST: begin
        cmd.test = 1'b1;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free || !sts.pend_vld;
      end
      ST_FINAL: begin
        cmd.final_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/smtd_dpath.sv
// ----------------------------------------------------------------------------
// smtd_dpath
// list stores, merge indices, gap and mismatch tests, pending pair and
// output register
// ----------------------------------------------------------------------------
`default_nettype none

module smtd_dpath import smtd_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_t                   in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output out_t                       out_data,
  input  wire cmd_t                  cmd,
  output sts_t                       sts
);

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
  localparam int PROD_W = TOL_W + 32;
  localparam int CMP_W  = DATA_W + 33;

  // configuration
  logic signed [GAP_W-1:0] gap_r;
  logic                    cmp_en_r;
  logic [TOL_W-1:0]        tol_r;

  // stores
  pair_t ex_mem [LIST_DEPTH];
  pair_t nu_mem [LIST_DEPTH];
  pair_t ex_rd_r;
  pair_t nu_rd_r;

  logic [CNT_W-1:0] ecnt_r, ecnt_nxt;
  logic [CNT_W-1:0] ncnt_r, ncnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;

  logic ex_wr, nu_wr, run_go;

  // candidate and last kept pair
  pair_t              cand_r;
  pair_t              pend_r;
  logic [TALLY_W-1:0] pend_tally_r;
  logic               pend_vld_r, pend_vld_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;

  // mismatch arithmetic
  logic signed [DATA_W:0] vdiff_r;
  logic [DATA_W-1:0]      mag_r;
  logic [DATA_W-1:0]      d_r;
  logic [PROD_W-1:0]      p_lo_r;
  logic [PROD_W-1:0]      p_hi_r;
  logic [31:0]            mul_a;
  logic [PROD_W-1:0]      prod;
  logic [DATA_W:0]        vdiff_neg;
  logic [CMP_W-1:0]       rhs, lhs;
  logic                   mismatch;

  logic signed [DATA_W:0] gap_diff;
  logic signed [DATA_W:0] gap_ext;
  logic                   gap_ok;
  logic                   take_ex;

  // output register
  out_t out_r;
  logic out_vld_r, out_vld_nxt;
  logic out_free;
  logic out_load;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r    <= '0;
      cmp_en_r <= 1'b0;
      tol_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_TIME_GAP:   gap_r    <= cfg_data[GAP_W-1:0];
        CFG_COMPARE_ENABLE: cmp_en_r <= cfg_data[0];
        CFG_TOLERANCE:      tol_r    <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ex_wr  = cmd.accept && (in_data.func == FUNC_LOAD_EXIST) && (ecnt_r < DEPTH_C);
  assign nu_wr  = cmd.accept && (in_data.func == FUNC_LOAD_FRESH) && (ncnt_r < DEPTH_C);
  assign run_go = cmd.accept && (in_data.func == FUNC_RUN);

  always_ff @(posedge clk) begin
    if (ex_wr) begin
      ex_mem[ecnt_r[ADDR_W-1:0]] <= '{ptime: in_data.sample_time, pval: in_data.sample_value};
    end
    ex_rd_r <= ex_mem[i_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nu_wr) begin
      nu_mem[ncnt_r[ADDR_W-1:0]] <= '{ptime: in_data.sample_time, pval: in_data.sample_value};
    end
    nu_rd_r <= nu_mem[j_r[ADDR_W-1:0]];
  end

  // merge order, existing first on equal times
  assign take_ex = (j_r >= ncnt_r) ||
                   ((i_r < ecnt_r) && (ex_rd_r.ptime <= nu_rd_r.ptime));

  // exact time step against the last kept pair
  assign gap_diff = {cand_r.ptime[DATA_W-1], cand_r.ptime} -
                    {pend_r.ptime[DATA_W-1], pend_r.ptime};
  assign gap_ext  = {{(DATA_W + 1 - GAP_W){gap_r[GAP_W-1]}}, gap_r};
  assign gap_ok   = gap_diff >= gap_ext;

  // shared multiplier, tolerance times one half of the kept magnitude
  assign mul_a = cmd.mul_hi ? mag_r[DATA_W-1:32] : mag_r[31:0];
  assign prod  = {32'b0, tol_r} * {{TOL_W{1'b0}}, mul_a};

  assign vdiff_neg = -vdiff_r;
  assign rhs = {{(CMP_W - PROD_W){1'b0}}, p_lo_r} +
               {{(CMP_W - PROD_W - 32){1'b0}}, p_hi_r, 32'b0};
  assign lhs = {{(CMP_W - DATA_W - FRAC_W){1'b0}}, d_r, {FRAC_W{1'b0}}};
  assign mismatch = (d_r > {{(DATA_W - TOL_W){1'b0}}, tol_r}) && (lhs > rhs);

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      cand_r <= take_ex ? ex_rd_r : nu_rd_r;
    end
    if (cmd.test) begin
      vdiff_r <= {cand_r.pval[DATA_W-1], cand_r.pval} -
                 {pend_r.pval[DATA_W-1], pend_r.pval};
      mag_r   <= pend_r.pval[DATA_W-1] ? (DATA_W'(0) - pend_r.pval) : pend_r.pval;
    end
    if (cmd.mul_lo) begin
      d_r    <= vdiff_r[DATA_W] ? vdiff_neg[DATA_W-1:0] : vdiff_r[DATA_W-1:0];
      p_lo_r <= prod;
    end
    if (cmd.mul_hi) begin
      p_hi_r <= prod;
    end
    if (cmd.emit) begin
      pend_r       <= cand_r;
      pend_tally_r <= tally_r;
    end
  end

  // counts, indices, tally, pending flag
  always_comb begin
    ecnt_nxt     = ecnt_r;
    ncnt_nxt     = ncnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    tally_nxt    = tally_r;
    pend_vld_nxt = pend_vld_r;
    if (ex_wr) ecnt_nxt = ecnt_r + 1'b1;
    if (nu_wr) ncnt_nxt = ncnt_r + 1'b1;
    if (run_go) begin
      i_nxt        = '0;
      j_nxt        = '0;
      tally_nxt    = '0;
      pend_vld_nxt = 1'b0;
    end
    if (cmd.pick) begin
      if (take_ex) i_nxt = i_r + 1'b1;
      else j_nxt = j_r + 1'b1;
    end
    if (cmd.check && mismatch && (tally_r != TALLY_MAX)) tally_nxt = tally_r + 1'b1;
    if (cmd.emit) pend_vld_nxt = 1'b1;
    if (cmd.final_out) begin
      ecnt_nxt = '0;
      ncnt_nxt = '0;
      i_nxt    = '0;
      j_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r     <= '0;
      ncnt_r     <= '0;
      i_r        <= '0;
      j_r        <= '0;
      tally_r    <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      ecnt_r     <= ecnt_nxt;
      ncnt_r     <= ncnt_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      tally_r    <= tally_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // output register
  assign out_free = !out_vld_r || !out_stall;
  assign out_load = cmd.final_out || (cmd.emit && pend_vld_r);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) out_vld_nxt = 1'b1;
    else if (!out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.final_out) begin
      if (pend_vld_r) begin
        out_r <= '{out_time: pend_r.ptime, out_value: pend_r.pval, out_valid: 1'b1,
                   mismatch_count: tally_r, last: 1'b1};
      end else begin
        out_r <= '{out_time: '0, out_value: '0, out_valid: 1'b0,
                   mismatch_count: '0, last: 1'b1};
      end
    end else if (cmd.emit && pend_vld_r) begin
      out_r <= '{out_time: pend_r.ptime, out_value: pend_r.pval, out_valid: 1'b1,
                 mismatch_count: pend_tally_r, last: 1'b0};
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign sts.run_req  = in_data.func == FUNC_RUN;
  assign sts.done     = (i_r >= ecnt_r) && (j_r >= ncnt_r);
  assign sts.keep     = !pend_vld_r || (ecnt_r == '0) || gap_ok;
  assign sts.cmp_en   = cmp_en_r;
  assign sts.out_free = out_free;
  assign sts.pend_vld = pend_vld_r;

  // a word is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output word overwritten while stalled");

  // store fill never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ecnt_r <= DEPTH_C) && (ncnt_r <= DEPTH_C))
    else $error("store count beyond depth");

  // a pick only happens while pairs remain
  a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |-> !sts.done)
    else $error("pick with both lists exhausted");

  // the run end clears both lists
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.final_out |=> (ecnt_r == '0) && (ncnt_r == '0))
    else $error("lists not cleared after run");

  // indices stay within the loaded counts
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (i_r <= ecnt_r) && (j_r <= ncnt_r))
    else $error("merge index beyond loaded count");

endmodule

`default_nettype wire
